>>> rtl/core/ring_queue_with_remove_unit_defines.svh
// Assertion macros for the ring queue block
`ifndef RING_QUEUE_WITH_REMOVE_UNIT_DEFINES_SVH
`define RING_QUEUE_WITH_REMOVE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define RQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define RQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/rqr_pkg.sv
package rqr_pkg;

    localparam int DEPTH_DEF    = 1024;
    localparam int HANDLE_W_DEF = 32;

    localparam int          SLOTS_W     = 11;
    localparam logic [10:0] SLOTS_RESET = 11'd1024;

    localparam logic [1:0] OP_POP    = 2'd0;
    localparam logic [1:0] OP_PUSH   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] handle_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle_out;
    } t_out_item;

endpackage

>>> rtl/core/rqr_ram.sv
module rqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rqr_step.sv
module rqr_step #(
    parameter int DEPTH = rqr_pkg::DEPTH_DEF
) (
    input  logic [$clog2(DEPTH)-1:0] i_idx,
    input  logic [$clog2(DEPTH):0]   i_ring,
    output logic [$clog2(DEPTH)-1:0] o_adv
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int RING_W = IDX_W + 1;

    logic [RING_W-1:0] w_inc;

    // index + 1, wrapping at the ring size
    assign w_inc = {1'b0, i_idx} + RING_W'(1);
    assign o_adv = (w_inc >= i_ring) ? '0 : w_inc[IDX_W-1:0];

endmodule

>>> rtl/core/ring_queue_with_remove_unit.sv
// Ring queue of handles with remove-by-value.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one item: an operation
// (pop, push, remove) and a handle. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns exactly one item per input item: status and popped handle.
// The block works on one item at a time; o_in_ready is high only between items.
// A push or an unused code goes straight to the result, a pop adds a registered slot
// read, and a remove compares one entry per scan step from the tail toward the head
// and, on a match, moves each later entry one place toward the tail.
// The next item can be accepted in the cycle after a result is registered.
// The sequencer works around the single read port of the slot RAM (registered read)
// and the one shared index stepper, which it uses once per cycle.
// A finished result sits in an output register; the next item is taken while it
// waits. If the receiver stalls with a result still held, the following item
// finishes its work and then waits until the output register frees up.
// i_cfg_we writes the ring size (clamped to 2..DEPTH) and empties the queue; write
// it only while the block is idle.
// Reset (synchronous, active low): queue empty, ring size 1024 (clamped to DEPTH),
// no result pending. Slot contents are not cleared; only written slots are read.
`include "ring_queue_with_remove_unit_defines.svh"

module ring_queue_with_remove_unit #(
    parameter int DEPTH        = rqr_pkg::DEPTH_DEF,
    parameter int HANDLE_WIDTH = rqr_pkg::HANDLE_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rqr_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rqr_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [rqr_pkg::SLOTS_W-1:0]     i_cfg_data
);

    import rqr_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int RING_W = IDX_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_DATA,
        S_SCAN_CMP,
        S_SH_RD,
        S_SH_WR,
        S_FINISH
    } t_state;

    t_state                  r_state;
    logic [1:0]              r_op;
    logic [HANDLE_WIDTH-1:0] r_h;
    logic [IDX_W-1:0]        r_head;
    logic [IDX_W-1:0]        r_tail;
    logic [IDX_W-1:0]        r_cur;
    logic [IDX_W-1:0]        r_wr_addr;
    logic [1:0]              r_status;
    logic [31:0]             r_result;
    logic [SLOTS_W-1:0]      r_slots;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [RING_W-1:0]       w_ring;
    logic [IDX_W-1:0]        w_adv;
    logic                    w_out_free;

    logic                    w_we;
    logic [IDX_W-1:0]        w_waddr;
    logic [HANDLE_WIDTH-1:0] w_wdata;
    logic                    w_re;
    logic [IDX_W-1:0]        w_raddr;
    logic [HANDLE_WIDTH-1:0] w_rdata;

    // ring size clamped to 2..DEPTH
    always_comb begin
        if (r_slots < SLOTS_W'(2)) begin
            w_ring = RING_W'(2);
        end else if (32'(r_slots) > 32'(DEPTH)) begin
            w_ring = RING_W'(DEPTH);
        end else begin
            w_ring = RING_W'(r_slots);
        end
    end

    rqr_step #(
        .DEPTH (DEPTH)
    ) u_step (
        .i_idx  (r_cur),
        .i_ring (w_ring),
        .o_adv  (w_adv)
    );

    rqr_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = r_h;
        w_re    = 1'b0;
        w_raddr = r_cur;
        case (r_state)
            S_EXEC: begin
                case (r_op)
                    OP_POP:    w_re = (r_cur != r_head);
                    OP_PUSH:   w_we = (w_adv != r_tail);
                    OP_REMOVE: w_re = (r_cur != r_head);
                    default:   ;
                endcase
            end
            S_SH_RD: begin
                w_re    = (w_adv != r_head);
                w_raddr = w_adv;
            end
            S_SH_WR: begin
                // move the later entry one place toward the tail
                w_we    = 1'b1;
                w_waddr = r_wr_addr;
                w_wdata = w_rdata;
            end
            default: ;
        endcase
    end

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_slots     <= SLOTS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            // in S_FINISH the output register is reloaded below instead
            if (r_out_valid && i_out_ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_slots <= i_cfg_data;
                r_head  <= '0;
                r_tail  <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.operation;
                        r_h     <= HANDLE_WIDTH'(i_in_data.handle_in);
                        r_cur   <= (i_in_data.operation == OP_PUSH) ? r_head : r_tail;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_result <= '0;
                    case (r_op)
                        OP_POP: begin
                            if (r_cur == r_head) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_FINISH;
                            end else begin
                                r_status <= ST_OK;
                                r_tail   <= w_adv;
                                r_state  <= S_POP_DATA;
                            end
                        end
                        OP_PUSH: begin
                            if (w_adv == r_tail) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_OK;
                                r_head   <= w_adv;
                            end
                            r_state <= S_FINISH;
                        end
                        OP_REMOVE: begin
                            // scan step: stop at head, else compare next cycle
                            if (r_cur == r_head) begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_FINISH;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_SCAN_CMP;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_state  <= S_FINISH;
                        end
                    endcase
                end
                S_POP_DATA: begin
                    r_result <= 32'(w_rdata);
                    r_state  <= S_FINISH;
                end
                S_SCAN_CMP: begin
                    if (w_rdata == r_h) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_cur   <= w_adv;
                        r_state <= S_EXEC;
                    end
                end
                S_SH_RD: begin
                    if (w_adv == r_head) begin
                        r_head  <= r_cur;
                        r_state <= S_FINISH;
                    end else begin
                        r_wr_addr <= r_cur;
                        r_cur     <= w_adv;
                        r_state   <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_state <= S_SH_RD;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out.status     <= r_status;
                        r_out.handle_out <= r_result;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RQR_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_EXEC, "accepted item did not start")
    `RQR_ASSERT_IMP(a_we_states, i_clk, i_rst_n, w_we,
        r_state == S_EXEC || r_state == S_SH_WR, "slot write outside push or shift")
    `RQR_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, r_out_valid && r_out.status == ST_EMPTY,
        r_out.handle_out == 32'd0, "empty pop with nonzero handle")
    `RQR_ASSERT_IMP(a_pop_read, i_clk, i_rst_n, r_state == S_POP_DATA,
        $past(w_re), "pop data without slot read")

endmodule

>>> sim/tb.sv
module tb;
    import rqr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RING_MAX = DEPTH_DEF;
    localparam int N_PHASES = 9;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_we = 1'b0;
    logic [SLOTS_W-1:0] i_cfg_data = '0;

    ring_queue_with_remove_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item predicted_replies[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int n_items = 0;
    int n_empty = 0;
    int n_full = 0;
    int n_hit = 0;
    int n_miss = 0;
    int n_settings = 0;
    logic [31:0] handle_pool [8];

    // shadow copy of the ring
    logic [31:0] model_slots [RING_MAX];
    logic [9:0] model_head = '0;
    logic [9:0] model_tail = '0;
    logic [SLOTS_W-1:0] model_ring_cfg = SLOTS_RESET;

    function automatic int ring_len();
        int n;
        n = int'(model_ring_cfg);
        if (n < 2) n = 2;
        if (n > RING_MAX) n = RING_MAX;
        return n;
    endfunction

    function automatic logic [9:0] ring_next(logic [9:0] i);
        logic [10:0] j;
        j = {1'b0, i} + 11'd1;
        return (j >= ring_len()) ? 10'd0 : j[9:0];
    endfunction

    task automatic predict_reply(input t_in_item it);
        t_out_item r;
        logic [9:0] cur;
        logic [9:0] nxt;
        bit found;
        r.status = ST_OK;
        r.handle_out = '0;
        n_items++;
        case (it.operation)
            OP_POP: begin
                if (model_tail == model_head) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    r.handle_out = model_slots[model_tail];
                    model_slots[model_tail] = '0;
                    model_tail = ring_next(model_tail);
                end
            end
            OP_PUSH: begin
                if (ring_next(model_head) == model_tail) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    model_slots[model_head] = it.handle_in;
                    model_head = ring_next(model_head);
                end
            end
            OP_REMOVE: begin
                cur = model_tail;
                found = 1'b0;
                while (cur != model_head && !found) begin
                    if (model_slots[cur] == it.handle_in) found = 1'b1;
                    else cur = ring_next(cur);
                end
                if (!found) begin
                    r.status = ST_NOT_FOUND;
                    n_miss++;
                end else begin
                    n_hit++;
                    // close the gap toward the tail, head steps back one
                    nxt = ring_next(cur);
                    while (nxt != model_head) begin
                        model_slots[cur] = model_slots[nxt];
                        cur = nxt;
                        nxt = ring_next(cur);
                    end
                    model_slots[cur] = '0;
                    model_head = cur;
                end
            end
            default: ;
        endcase
        predicted_replies.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_data <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                model_ring_cfg = i_cfg_data;
                model_head = '0;
                model_tail = '0;
            end
            if (i_in_valid && o_in_ready) predict_reply(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (predicted_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: status %0d handle %h",
                                 o_out_data.status, o_out_data.handle_out);
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_out_data.status !== want.status ||
                        o_out_data.handle_out !== want.handle_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status %0d handle %h, got %0d %h",
                                     want.status, want.handle_out,
                                     o_out_data.status, o_out_data.handle_out);
                    end
                end
            end
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [31:0] h);
        t_in_item it;
        it.operation = op;
        it.handle_in = h;
        pending_items.push_back(it);
    endtask

    task automatic add_random(input int n);
        int mood;
        int r;
        int t_push;
        int t_pop;
        int t_rem;
        logic [1:0] op;
        logic [31:0] h;
        mood = 0;
        for (int k = 0; k < n; k++) begin
            // bias changes every 20 items so the ring reaches full and empty
            if (k % 20 == 0) mood = $urandom_range(0, 3);
            case (mood)
                0: begin t_push = 70; t_pop = 85; t_rem = 97; end
                1: begin t_push = 25; t_pop = 80; t_rem = 97; end
                2: begin t_push = 40; t_pop = 55; t_rem = 97; end
                default: begin t_push = 40; t_pop = 70; t_rem = 95; end
            endcase
            r = $urandom_range(0, 99);
            op = (r < t_push) ? OP_PUSH : (r < t_pop) ? OP_POP :
                 (r < t_rem) ? OP_REMOVE : OP_UNUSED;
            h = ($urandom_range(0, 99) < 70) ? handle_pool[$urandom_range(0, 7)] : $urandom;
            add_item(op, h);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || predicted_replies.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_ring(input logic [SLOTS_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            1: begin send_idle_pct = 45; recv_idle_pct = 0; end
            2: begin send_idle_pct = 0; recv_idle_pct = 45; end
            3: begin send_idle_pct = 14; recv_idle_pct = 14; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    initial begin
        int ph_slots [N_PHASES];
        int ph_items [N_PHASES];
        int ph_mode [N_PHASES];
        int half;
        ph_slots = '{2, 0, 1, 5, 8, 16, 2047, 1024, 0};
        ph_items = '{60, 40, 40, 100, 120, 120, 80, 80, 110};
        ph_mode = '{1, 2, 3, 0, 1, 2, 3, 0, 3};
        for (int i = 0; i < RING_MAX; i++) model_slots[i] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset ring size: empty cases, duplicates, removes at tail, middle and end
        set_idle(0);
        add_item(OP_POP, 32'h0);
        add_item(OP_REMOVE, 32'h7);
        add_item(OP_UNUSED, 32'hFFFF_FFFF);
        add_item(OP_PUSH, 32'h0);
        add_item(OP_PUSH, 32'hFFFF_FFFF);
        add_item(OP_PUSH, 32'h1234_5678);
        add_item(OP_PUSH, 32'hFFFF_FFFF);
        add_item(OP_PUSH, 32'hA5A5_A5A5);
        add_item(OP_REMOVE, 32'hFFFF_FFFF);
        add_item(OP_REMOVE, 32'hA5A5_A5A5);
        add_item(OP_REMOVE, 32'hDEAD_BEEF);
        add_item(OP_REMOVE, 32'h0);
        add_item(OP_POP, 32'h0);
        add_item(OP_POP, 32'h0);
        add_item(OP_POP, 32'h0);
        wait_drained();

        // three-slot ring: full, wraparound, remove across the wrap
        set_ring(11'd3);
        add_item(OP_PUSH, 32'h11);
        add_item(OP_PUSH, 32'h22);
        add_item(OP_PUSH, 32'h33);
        add_item(OP_POP, 32'h0);
        add_item(OP_PUSH, 32'h33);
        add_item(OP_PUSH, 32'h44);
        add_item(OP_REMOVE, 32'h33);
        add_item(OP_PUSH, 32'h55);
        add_item(OP_REMOVE, 32'h22);
        add_item(OP_POP, 32'h0);
        add_item(OP_POP, 32'h0);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == N_PHASES - 1) ph_slots[p] = $urandom_range(2, 40);
            set_ring(SLOTS_W'(ph_slots[p]));
            set_idle(ph_mode[p]);
            handle_pool[0] = 32'h0;
            handle_pool[1] = 32'hFFFF_FFFF;
            for (int k = 2; k < 8; k++) handle_pool[k] = $urandom;
            half = ph_items[p] / 2;
            add_random(half);
            // sender holds off until the queue of replies is empty
            wait_drained();
            add_random(ph_items[p] - half);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("%0d items over %0d ring settings; %0d empty pops, %0d full pushes",
                 n_items, n_settings, n_empty, n_full);
        $display("removes: %0d found, %0d not found", n_hit, n_miss);
        if (mismatches == 0 && predicted_replies.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rqr_pkg.sv
rtl/core/rqr_ram.sv
rtl/core/rqr_step.sv
rtl/core/ring_queue_with_remove_unit.sv
sim/tb.sv
